// ===== rtl/fras_pkg.sv =====
// shared types and constants for the fragment reassembler
package fras_pkg;

	localparam int unsigned MaxMessageBytes = 1024;
	localparam int unsigned MsgCntW = $clog2(MaxMessageBytes + 1);
	localparam int unsigned QDepth = 2;

	localparam logic [1:0] OP_RX = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_TAKE = 2'd2;
	localparam logic [1:0] OP_REL = 2'd3;

	localparam logic [7:0] F_START = 8'h01;
	localparam logic [7:0] F_CONT = 8'h02;
	localparam logic [7:0] F_END = 8'h04;
	localparam logic [7:0] F_ACK = 8'h08;
	localparam logic [7:0] SEQ_MASK = 8'hff;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROG = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_ERR = 2'd3;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_BAD_SEQ = 3'd1;
	localparam logic [2:0] STS_BAD_FLAGS = 3'd2;
	localparam logic [2:0] STS_HDR_LONG = 3'd3;
	localparam logic [2:0] STS_TOO_BIG = 3'd4;
	localparam logic [2:0] STS_MISSING = 3'd5;
	localparam logic [2:0] STS_IN_ERR = 3'd6;
	localparam logic [2:0] STS_SHORT = 3'd7;

	localparam logic [2:0] HP_FLAGS = 3'd0;
	localparam logic [2:0] HP_ACK = 3'd1;
	localparam logic [2:0] HP_SEQ = 3'd2;
	localparam logic [2:0] HP_LEN_LO = 3'd3;
	localparam logic [2:0] HP_LEN_HI = 3'd4;
	localparam logic [2:0] HP_PAYLOAD = 3'd5;

	localparam logic CFG_FRAG_SIZE = 1'b0;
	localparam logic CFG_FIRST_ACK = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] in_byte;
		logic       fragment_last;
		logic       in_limit;
	} fras_item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       ack_seen;
		logic [7:0] ack_number;
		logic       fragment_done;
		logic [2:0] status;
		logic       message_complete;
		logic [7:0] seq_out;
		logic       has_unacked;
		logic [1:0] rx_state;
	} fras_result_t;

	function automatic logic [7:0] seq_inc(input logic [7:0] s);
		return (s + 8'd1) & SEQ_MASK;
	endfunction

endpackage

// ===== rtl/fras_front.sv =====
// front part: takes items, tracks the fragment byte index and tags in-limit bytes
module fras_front import fras_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [1:0]       opcode,
	input  logic [7:0]       in_byte,
	input  logic             fragment_last,
	input  logic [15:0]      frag_size,
	input  logic             q_full,
	output logic             push,
	output fras_item_t       item
);

	logic [15:0] byte_count_q;
	logic [15:0] idx;

	assign ready = !q_full;
	assign push  = valid && ready;
	assign idx   = byte_count_q;

	always_comb begin
		item.opcode        = opcode;
		item.in_byte       = in_byte;
		item.fragment_last = fragment_last;
		item.in_limit      = (idx < frag_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
		end else if (push && opcode == OP_RX) begin
			if (fragment_last) begin
				byte_count_q <= '0;
			end else if (byte_count_q != 16'hffff) begin
				byte_count_q <= byte_count_q + 16'd1;
			end
		end
	end

endmodule

// ===== rtl/fras_queue.sv =====
// short queue between front and back
module fras_queue import fras_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fras_item_t push_item,
	output logic       full,
	output logic       not_empty,
	input  logic       pop,
	output fras_item_t head
);

	localparam int unsigned PtrW = $clog2(QDepth);

	fras_item_t       mem_q [QDepth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [PtrW:0]    cnt_q;

	assign full      = (cnt_q == (PtrW+1)'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

endmodule

// ===== rtl/fras_back.sv =====
// back part: header parsing, sequence and ack state, result register
module fras_back import fras_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  fras_item_t   item,
	output logic         pop,
	input  logic         cfg_first_wr,
	input  logic         cfg_first_val,
	output logic         out_valid,
	input  logic         out_ready,
	output fras_result_t result
);

	logic [1:0]         rstate_q;
	logic [2:0]         hpos_q;
	logic [7:0]         hflags_q;
	logic               drop_q, resync_q;
	logic [2:0]         fstat_q;
	logic [15:0]        mlen_q;
	logic [MsgCntW-1:0] mcnt_q;
	logic [7:0]         rx_next_q, rx_newest_q, rx_oldest_q;
	logic [7:0]         tx_next_q, tx_newest_q, tx_oldest_q;
	logic               awaiting_q;

	logic [1:0]         rstate_d;
	logic [2:0]         hpos_d;
	logic [7:0]         hflags_d;
	logic               drop_d, resync_d;
	logic [2:0]         fstat_d;
	logic [15:0]        mlen_d;
	logic [MsgCntW-1:0] mcnt_d;
	logic [7:0]         rx_next_d, rx_newest_d, rx_oldest_d;
	logic [7:0]         tx_next_d, tx_newest_d, tx_oldest_d;
	logic               awaiting_d;
	fras_result_t       res_d;
	logic               ack_ok;
	logic [7:0]         b;

	assign pop = q_not_empty && (!out_valid || out_ready);
	assign b   = item.in_byte;

	always_comb begin
		if (!awaiting_q) begin
			ack_ok = 1'b0;
		end else if (tx_newest_q >= tx_oldest_q) begin
			ack_ok = (b <= tx_newest_q) && (b >= tx_oldest_q);
		end else begin
			ack_ok = (b <= tx_newest_q) || (b >= tx_oldest_q);
		end
	end

	always_comb begin
		rstate_d    = rstate_q;
		hpos_d      = hpos_q;
		hflags_d    = hflags_q;
		drop_d      = drop_q;
		resync_d    = resync_q;
		fstat_d     = fstat_q;
		mlen_d      = mlen_q;
		mcnt_d      = mcnt_q;
		rx_next_d   = rx_next_q;
		rx_newest_d = rx_newest_q;
		rx_oldest_d = rx_oldest_q;
		tx_next_d   = tx_next_q;
		tx_newest_d = tx_newest_q;
		tx_oldest_d = tx_oldest_q;
		awaiting_d  = awaiting_q;
		res_d       = '0;
		unique case (item.opcode)
			OP_RX: begin
				if (hpos_q == HP_FLAGS) begin
					fstat_d  = STS_OK;
					drop_d   = 1'b0;
					resync_d = 1'b0;
				end
				if (!drop_d) begin
					unique case (hpos_q)
						HP_FLAGS: begin
							hflags_d = b;
							hpos_d   = ((b & F_ACK) != '0) ? HP_ACK : HP_SEQ;
						end
						HP_ACK: begin
							res_d.ack_number = b;
							hpos_d = HP_SEQ;
							if (ack_ok) begin
								res_d.ack_seen = 1'b1;
								if (tx_newest_q == b) begin
									tx_oldest_d = b;
									awaiting_d  = 1'b0;
								end else begin
									tx_oldest_d = seq_inc(b);
								end
							end else begin
								resync_d = 1'b1;
							end
						end
						HP_SEQ: begin
							rx_newest_d = b;
							if (resync_q) begin
								rx_next_d = seq_inc(b);
								resync_d  = 1'b0;
								drop_d    = 1'b1;
							end else if (b < rx_next_q) begin
								drop_d = 1'b1;
							end else if (b != rx_next_q) begin
								rstate_d = ST_ERR; fstat_d = STS_BAD_SEQ; drop_d = 1'b1;
							end else begin
								rx_next_d = seq_inc(rx_next_q);
								if ((hflags_q & (F_START | F_CONT | F_END)) == '0) begin
									drop_d = 1'b1;
								end else if (!item.in_limit) begin
									rstate_d = ST_ERR; fstat_d = STS_HDR_LONG; drop_d = 1'b1;
								end else if (rstate_q == ST_IDLE) begin
									if ((hflags_q & F_START) != '0) begin
										hpos_d = HP_LEN_LO;
									end else begin
										rstate_d = ST_ERR; fstat_d = STS_BAD_FLAGS;
										drop_d = 1'b1;
									end
								end else if (rstate_q == ST_PROG) begin
									if ((hflags_q & F_START) != '0 ||
									    (hflags_q & (F_CONT | F_END)) == '0) begin
										rstate_d = ST_ERR; fstat_d = STS_BAD_FLAGS;
										drop_d = 1'b1;
									end else begin
										hpos_d = HP_PAYLOAD;
									end
								end else begin
									rstate_d = ST_ERR; fstat_d = STS_IN_ERR; drop_d = 1'b1;
								end
							end
						end
						HP_LEN_LO: begin
							if (item.in_limit) begin
								mlen_d = {8'd0, b};
								hpos_d = HP_LEN_HI;
							end
						end
						HP_LEN_HI: begin
							if (item.in_limit) begin
								mlen_d   = {b, mlen_q[7:0]};
								rstate_d = ST_PROG;
								mcnt_d   = '0;
								hpos_d   = HP_PAYLOAD;
							end
						end
						default: begin
							if (item.in_limit) begin
								if (mcnt_q >= MsgCntW'(MaxMessageBytes)) begin
									rstate_d = ST_ERR; fstat_d = STS_TOO_BIG; drop_d = 1'b1;
								end else begin
									if (16'(mcnt_q) < mlen_q) begin
										res_d.data_valid = 1'b1;
										res_d.data_byte  = b;
									end
									mcnt_d = mcnt_q + 1'b1;
								end
							end
						end
					endcase
				end
				if (item.fragment_last) begin
					if (!drop_d) begin
						if (hpos_d < HP_PAYLOAD) begin
							rstate_d = ST_ERR; fstat_d = STS_SHORT;
						end else if ((hflags_d & F_END) != '0) begin
							if (16'(mcnt_d) >= mlen_d) begin
								rstate_d = ST_DONE;
								res_d.message_complete = 1'b1;
							end else begin
								rstate_d = ST_ERR; fstat_d = STS_MISSING;
							end
						end
					end
					res_d.fragment_done = 1'b1;
					hpos_d   = HP_FLAGS;
					drop_d   = 1'b0;
					resync_d = 1'b0;
				end
				res_d.status = fstat_d;
			end
			OP_ALLOC: begin
				res_d.seq_out = tx_next_q;
				if (!awaiting_q) begin
					awaiting_d  = 1'b1;
					tx_oldest_d = tx_next_q;
				end
				tx_newest_d = tx_next_q;
				tx_next_d   = seq_inc(tx_next_q);
			end
			OP_TAKE: begin
				res_d.seq_out = rx_newest_q;
				rx_newest_d   = rx_next_q;
				rx_oldest_d   = rx_next_q;
			end
			default: begin
				if (rstate_q == ST_DONE) begin
					rstate_d = ST_IDLE;
				end
			end
		endcase
		res_d.has_unacked = (rx_oldest_d != rx_next_d);
		res_d.rx_state    = rstate_d;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			rstate_q    <= ST_IDLE;
			hpos_q      <= HP_FLAGS;
			hflags_q    <= '0;
			drop_q      <= 1'b0;
			resync_q    <= 1'b0;
			fstat_q     <= STS_OK;
			mlen_q      <= '0;
			mcnt_q      <= '0;
			rx_next_q   <= 8'd1;
			rx_newest_q <= '0;
			rx_oldest_q <= '0;
			tx_next_q   <= '0;
			tx_newest_q <= '0;
			tx_oldest_q <= '0;
			awaiting_q  <= 1'b0;
		end else if (cfg_first_wr) begin
			rx_newest_q <= '0;
			rx_oldest_q <= '0;
			tx_newest_q <= '0;
			tx_oldest_q <= '0;
			tx_next_q   <= {7'd0, cfg_first_val};
			awaiting_q  <= cfg_first_val;
			rx_next_q   <= {7'd0, !cfg_first_val};
		end else begin
			if (pop) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (pop) begin
				rstate_q    <= rstate_d;
				hpos_q      <= hpos_d;
				hflags_q    <= hflags_d;
				drop_q      <= drop_d;
				resync_q    <= resync_d;
				fstat_q     <= fstat_d;
				mlen_q      <= mlen_d;
				mcnt_q      <= mcnt_d;
				rx_next_q   <= rx_next_d;
				rx_newest_q <= rx_newest_d;
				rx_oldest_q <= rx_oldest_d;
				tx_next_q   <= tx_next_d;
				tx_newest_q <= tx_newest_d;
				tx_oldest_q <= tx_oldest_d;
				awaiting_q  <= awaiting_d;
			end
		end
	end

endmodule

// ===== rtl/fragment_reassembler_seq_ack.sv =====
// top level of the fragment reassembler with sequence and ack tracking
// One item a cycle while the output is not stalled: the front tags each byte with its
// position against the fragment size, a two-entry queue feeds the back, which parses the
// header, moves the sequence and ack windows and registers one result item per input item.
// Each item is held in the queue and then in the back's result register; while the output
// stalls the queue still takes items until it holds two, and then ready drops.
module fragment_reassembler_seq_ack import fras_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  in_byte,
	input  logic        fragment_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        ack_seen,
	output logic [7:0]  ack_number,
	output logic        fragment_done,
	output logic [2:0]  status,
	output logic        message_complete,
	output logic [7:0]  seq_out,
	output logic        has_unacked,
	output logic [1:0]  rx_state
);

	logic [15:0]  frag_size_q;
	logic         q_full, q_not_empty, push, pop, cfg_wr;
	fras_item_t   f_item, q_head;
	fras_result_t res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_size_q <= 16'd512;
		end else if (cfg_wr && cfg_index == CFG_FRAG_SIZE) begin
			frag_size_q <= cfg_data;
		end
	end

	fras_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .opcode(opcode),
		.in_byte(in_byte), .fragment_last(fragment_last), .frag_size(frag_size_q),
		.q_full(q_full), .push(push), .item(f_item)
	);

	fras_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(f_item), .full(q_full),
		.not_empty(q_not_empty), .pop(pop), .head(q_head)
	);

	fras_back u_back (
		.clk(clk), .arst_n(arst_n), .q_not_empty(q_not_empty), .item(q_head), .pop(pop),
		.cfg_first_wr(cfg_wr && cfg_index == CFG_FIRST_ACK), .cfg_first_val(cfg_data[0]),
		.out_valid(out_valid), .out_ready(out_ready), .result(res)
	);

	assign data_valid       = res.data_valid;
	assign data_byte        = res.data_byte;
	assign ack_seen         = res.ack_seen;
	assign ack_number       = res.ack_number;
	assign fragment_done    = res.fragment_done;
	assign status           = res.status;
	assign message_complete = res.message_complete;
	assign seq_out          = res.seq_out;
	assign has_unacked      = res.has_unacked;
	assign rx_state         = res.rx_state;

endmodule

// ===== test/fras_checker.sv =====
`timescale 1ns / 100ps
// result checker for the fragment reassembler: mirrors its parsing and compares each result item
module fras_checker import fras_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  in_byte,
	input  logic        fragment_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        data_valid,
	input  logic [7:0]  data_byte,
	input  logic        ack_seen,
	input  logic [7:0]  ack_number,
	input  logic        fragment_done,
	input  logic [2:0]  status,
	input  logic        message_complete,
	input  logic [7:0]  seq_out,
	input  logic        has_unacked,
	input  logic [1:0]  rx_state,
	output int          fails,
	output int          pending
);

	logic [15:0] frag_size;
	logic        first_ack;
	logic [1:0]  rstate;
	logic [2:0]  hpos;
	logic [7:0]  hflags;
	logic        drop, resync;
	logic [2:0]  fstat;
	logic [15:0] fcnt, mlen, mcnt;
	logic [7:0]  rx_next, rx_newest, rx_oldest;
	logic [7:0]  tx_next, tx_newest, tx_oldest;
	logic        awaiting;

	fras_result_t pending_results[$];

	function automatic void restart_seq();
		rx_newest = '0;
		rx_oldest = '0;
		tx_newest = '0;
		tx_oldest = '0;
		awaiting  = first_ack;
		tx_next   = first_ack ? 8'd1 : 8'd0;
		rx_next   = first_ack ? 8'd0 : 8'd1;
	endfunction

	function automatic void enter_error(logic [2:0] code);
		rstate = ST_ERR;
		fstat  = code;
		drop   = 1'b1;
	endfunction

	function automatic logic ack_in_window(logic [7:0] a);
		if (!awaiting)
			return 1'b0;
		if (tx_newest >= tx_oldest)
			return a <= tx_newest && a >= tx_oldest;
		return a <= tx_newest || a >= tx_oldest;
	endfunction

	function automatic fras_result_t reassemble_step(logic [1:0] op, logic [7:0] b, logic last);
		fras_result_t r;
		logic [15:0]  idx;
		r = '0;
		if (op == OP_RX) begin
			idx = fcnt;
			if (hpos == HP_FLAGS) begin
				fstat  = STS_OK;
				drop   = 1'b0;
				resync = 1'b0;
			end
			if (fcnt != 16'hffff)
				fcnt = fcnt + 16'd1;
			if (!drop) begin
				case (hpos)
					HP_FLAGS: begin
						hflags = b;
						hpos   = ((b & F_ACK) != 0) ? HP_ACK : HP_SEQ;
					end
					HP_ACK: begin
						r.ack_number = b;
						hpos = HP_SEQ;
						if (ack_in_window(b)) begin
							r.ack_seen = 1'b1;
							if (tx_newest == b) begin
								tx_oldest = b;
								awaiting  = 1'b0;
							end else
								tx_oldest = b + 8'd1;
						end else
							resync = 1'b1;
					end
					HP_SEQ: begin
						rx_newest = b;
						if (resync) begin
							rx_next = b + 8'd1;
							resync  = 1'b0;
							drop    = 1'b1;
						end else if (b < rx_next)
							drop = 1'b1;
						else if (b != rx_next)
							enter_error(STS_BAD_SEQ);
						else begin
							rx_next = rx_next + 8'd1;
							if ((hflags & (F_START | F_CONT | F_END)) == 0)
								drop = 1'b1;
							else if ({1'b0, idx} + 17'd1 > {1'b0, frag_size})
								enter_error(STS_HDR_LONG);
							else if (rstate == ST_IDLE) begin
								if ((hflags & F_START) != 0)
									hpos = HP_LEN_LO;
								else
									enter_error(STS_BAD_FLAGS);
							end else if (rstate == ST_PROG) begin
								if ((hflags & F_START) != 0 || (hflags & (F_CONT | F_END)) == 0)
									enter_error(STS_BAD_FLAGS);
								else
									hpos = HP_PAYLOAD;
							end else
								enter_error(STS_IN_ERR);
						end
					end
					HP_LEN_LO: begin
						if (idx < frag_size) begin
							mlen = {8'd0, b};
							hpos = HP_LEN_HI;
						end
					end
					HP_LEN_HI: begin
						if (idx < frag_size) begin
							mlen   = mlen | {b, 8'd0};
							rstate = ST_PROG;
							mcnt   = '0;
							hpos   = HP_PAYLOAD;
						end
					end
					default: begin
						if (idx < frag_size) begin
							if (mcnt >= 16'(MaxMessageBytes))
								enter_error(STS_TOO_BIG);
							else begin
								if (mcnt < mlen) begin
									r.data_valid = 1'b1;
									r.data_byte  = b;
								end
								mcnt = mcnt + 16'd1;
							end
						end
					end
				endcase
			end
			if (last) begin
				if (!drop) begin
					if (hpos < HP_PAYLOAD)
						enter_error(STS_SHORT);
					else if ((hflags & F_END) != 0) begin
						if (mcnt >= mlen) begin
							rstate = ST_DONE;
							r.message_complete = 1'b1;
						end else
							enter_error(STS_MISSING);
					end
				end
				r.fragment_done = 1'b1;
				hpos   = HP_FLAGS;
				drop   = 1'b0;
				resync = 1'b0;
				fcnt   = '0;
			end
			r.status = fstat;
		end else if (op == OP_ALLOC) begin
			r.seq_out = tx_next;
			if (!awaiting) begin
				awaiting  = 1'b1;
				tx_oldest = tx_next;
			end
			tx_newest = tx_next;
			tx_next   = tx_next + 8'd1;
		end else if (op == OP_TAKE) begin
			r.seq_out = rx_newest;
			rx_newest = rx_next;
			rx_oldest = rx_next;
		end else if (rstate == ST_DONE)
			rstate = ST_IDLE;
		r.has_unacked = rx_oldest != rx_next;
		r.rx_state    = rstate;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fras_result_t e;
		if (!arst_n) begin
			frag_size = 16'd512;
			first_ack = 1'b0;
			rstate    = ST_IDLE;
			hpos      = HP_FLAGS;
			hflags    = '0;
			drop      = 1'b0;
			resync    = 1'b0;
			fstat     = STS_OK;
			fcnt      = '0;
			mlen      = '0;
			mcnt      = '0;
			restart_seq();
			pending_results.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing expected");
					fails++;
				end else begin
					e = pending_results.pop_front();
					check_field("data_valid", 8'(e.data_valid), 8'(data_valid));
					check_field("data_byte", e.data_byte, data_byte);
					check_field("ack_seen", 8'(e.ack_seen), 8'(ack_seen));
					check_field("ack_number", e.ack_number, ack_number);
					check_field("fragment_done", 8'(e.fragment_done), 8'(fragment_done));
					check_field("status", 8'(e.status), 8'(status));
					check_field("message_complete", 8'(e.message_complete),
						8'(message_complete));
					check_field("seq_out", e.seq_out, seq_out);
					check_field("has_unacked", 8'(e.has_unacked), 8'(has_unacked));
					check_field("rx_state", 8'(e.rx_state), 8'(rx_state));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FRAG_SIZE)
					frag_size = cfg_data;
				else begin
					first_ack = cfg_data[0];
					restart_seq();
				end
			end
			if (valid && ready)
				pending_results.push_back(reassemble_step(opcode, in_byte, fragment_last));
			pending = pending_results.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// top of the fragment reassembler testbench: clock, reset, stimulus and verdict
module tb_top;
	import fras_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  in_byte;
	logic        fragment_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_ready;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic        ack_seen;
	logic [7:0]  ack_number;
	logic        fragment_done;
	logic [2:0]  status;
	logic        message_complete;
	logic [7:0]  seq_out;
	logic        has_unacked;
	logic [1:0]  rx_state;
	int          fails;
	int          pending;

	int send_idle;
	int recv_stall;
	int items_sent;

	fragment_reassembler_seq_ack DUT (.*);
	fras_checker chk (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk)
		out_ready = ($urandom_range(99) >= recv_stall);

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic drive_item(input logic [1:0] op, input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle) begin
			valid = 1'b0;
			@(negedge clk);
		end
		valid         = 1'b1;
		opcode        = op;
		in_byte       = b;
		fragment_last = last;
		do
			@(posedge clk);
		while (!ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(input logic [15:0] frag, input logic first);
		wait_idle();
		write_reg(CFG_FRAG_SIZE, frag);
		write_reg(CFG_FIRST_ACK, {15'd0, first});
	endtask

	// seq byte is rx_next plus delta, taken when it is sent
	task automatic push_fragment(input logic [7:0] flags, input logic [7:0] ackv,
			input int delta, input logic [15:0] len, input int npay);
		int total;
		int k;
		total = 2 + (((flags & F_ACK) != 0) ? 1 : 0) + (((flags & F_START) != 0) ? 2 : 0) + npay;
		k = 1;
		drive_item(OP_RX, flags, k == total);
		if ((flags & F_ACK) != 0) begin
			k++;
			drive_item(OP_RX, ackv, k == total);
		end
		k++;
		drive_item(OP_RX, chk.rx_next + 8'(delta), k == total);
		if ((flags & F_START) != 0) begin
			k++;
			drive_item(OP_RX, len[7:0], k == total);
			k++;
			drive_item(OP_RX, len[15:8], k == total);
		end
		repeat (npay) begin
			k++;
			drive_item(OP_RX, 8'($urandom), k == total);
		end
	endtask

	function automatic logic [7:0] good_ack();
		return $urandom_range(1) ? chk.tx_newest : chk.tx_oldest;
	endfunction

	// whole message over one to three fragments, then released
	task automatic push_message();
		int nfrag;
		int pay[3];
		int sum;
		logic [7:0] flags;
		nfrag = $urandom_range(1, 3);
		sum = 0;
		for (int i = 0; i < nfrag; i++) begin
			pay[i] = $urandom_range(0, 12);
			sum += pay[i];
		end
		for (int i = 0; i < nfrag; i++) begin
			flags = (i == 0) ? F_START : F_CONT;
			if (i == nfrag - 1)
				flags = flags | F_END;
			if (chk.awaiting && $urandom_range(2) == 0)
				flags = flags | F_ACK;
			push_fragment(flags, good_ack(), 0, 16'($urandom_range(0, sum)), pay[i]);
		end
		drive_item(OP_REL, 8'($urandom), 1'($urandom));
	endtask

	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55)
				push_message();
			else if (pick < 70)
				drive_item(OP_ALLOC, 8'($urandom), 1'($urandom));
			else if (pick < 80)
				drive_item(OP_TAKE, 8'($urandom), 1'($urandom));
			else if (pick < 88)
				push_fragment(F_ACK, $urandom_range(3) ? good_ack() : 8'($urandom), 0, 0,
					$urandom_range(0, 2));
			else if (pick < 94 && chk.rx_next != 0)
				push_fragment(F_START | F_END, 0, -1, 0, $urandom_range(0, 3));
			else
				drive_item(OP_REL, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		valid         = 1'b0;
		opcode        = OP_RX;
		in_byte       = '0;
		fragment_last = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		out_ready     = 1'b0;
		send_idle     = 20;
		recv_stall    = 81;
		items_sent    = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: ops, acked message, invalid stand-alone ack, flagless fragment, duplicate, two-fragment message
		drive_item(OP_ALLOC, 8'h00, 1'b0);
		push_fragment(F_START | F_END | F_ACK, chk.tx_newest, 0, 16'd3, 3);
		drive_item(OP_REL, 8'hff, 1'b1);
		drive_item(OP_REL, 8'h00, 1'b0);
		drive_item(OP_TAKE, 8'h00, 1'b0);
		push_fragment(F_ACK, 8'h77, 0, 0, 1);
		push_fragment(8'h00, 0, 0, 0, 1);
		push_fragment(F_START | F_END, 0, -1, 16'd2, 2);
		push_fragment(F_START, 0, 0, 16'd4, 2);
		push_fragment(F_CONT | F_END, 0, 0, 0, 2);
		drive_item(OP_REL, 8'h00, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle  = (phase == 0) ? 20 : (phase == 1) ? 81 : 0;
			recv_stall = (phase == 0) ? 81 : (phase == 1) ? 20 : 0;
			setup((phase == 1) ? 16'd20 : 16'd512, phase[0]);
			random_traffic(225);
			setup((phase == 2) ? 16'd20 : 16'hffff, !phase[0]);
			random_traffic(225);
		end

		// closing errors: the error state is sticky, so they come last
		setup(16'hffff, 1'b0);
		case ($urandom_range(2))
			0: push_fragment(F_START | F_END, 0, 0, 16'hffff, MaxMessageBytes + 6);
			1: push_fragment(F_START | F_END, 0, 0, 16'd50, 3);
			default: begin
				push_fragment(F_START, 0, 0, 16'd20, 2);
				push_fragment(F_START | F_END, 0, 0, 16'd5, 1);
			end
		endcase
		push_fragment(F_CONT | F_END, 0, 0, 0, 2);
		push_fragment(F_CONT, 0, 3, 0, 1);
		drive_item(OP_RX, F_CONT, 1'b1);
		setup(16'd3, 1'b1);
		push_fragment(F_START | F_END, 0, 0, 16'd1, 2);

		wait_idle();
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
